>>> src/grb_pkg.sv
// shared constants and types for the pin controller register block
`timescale 1ns / 1ps
`default_nettype none
package grb_pkg;

  localparam int PIN_COUNT    = 54;
  localparam int WORD_BITS    = 32;
  localparam int IDX_W        = 6;
  localparam int FN_W         = 3;
  localparam int PULL_W       = 2;
  localparam int PINS_PER_SEL = 10;
  localparam int SEL_WORDS    = 6;
  localparam int SEL_PINS     = SEL_WORDS * PINS_PER_SEL;
  localparam int SEL_BITS     = PINS_PER_SEL * FN_W;
  localparam int LEV_BITS     = 2 * WORD_BITS;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [IDX_W-1:0] IDX_FSEL_FIRST = 6'd0;
  localparam logic [IDX_W-1:0] IDX_FSEL_LAST  = 6'd5;
  localparam logic [IDX_W-1:0] IDX_SET0       = 6'd7;
  localparam logic [IDX_W-1:0] IDX_CLR0       = 6'd10;
  localparam logic [IDX_W-1:0] IDX_LEV0       = 6'd13;
  localparam logic [IDX_W-1:0] IDX_LEV1       = 6'd14;
  localparam logic [IDX_W-1:0] IDX_PULL       = 6'd37;
  localparam logic [IDX_W-1:0] IDX_CLK0       = 6'd38;
  localparam logic [IDX_W-1:0] IDX_CLK1       = 6'd39;

  localparam logic [FN_W-1:0]   FN_OUTPUT = 3'b001;
  localparam logic [PULL_W-1:0] PULL_DOWN = 2'd1;
  localparam logic [PULL_W-1:0] PULL_UP   = 2'd2;

  typedef struct packed {
    logic                 op;
    logic [IDX_W-1:0]     idx;
    logic [WORD_BITS-1:0] data;
  } req_t;

endpackage
`default_nettype wire

>>> src/grb_in_stage.sv
// input register stage holding one bus request
`timescale 1ns / 1ps
`default_nettype none
module grb_in_stage import grb_pkg::*; #(
  parameter int PinCount = PIN_COUNT
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire req_t                req_i,
  input  wire logic [PinCount-1:0] levels_i,
  input  wire logic                out_ready_i,
  output      logic                go_o,
  output      req_t                req_o,
  output      logic [PinCount-1:0] levels_o
);

  logic valid_q, valid_d;
  logic load;
  req_t req_q;
  logic [PinCount-1:0] levels_q;

  assign in_stall_o = valid_q && !out_ready_i;
  assign go_o       = valid_q && out_ready_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (go_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q    <= req_i;
      levels_q <= levels_i;
    end
  end

  assign req_o    = req_q;
  assign levels_o = levels_q;

endmodule
`default_nettype wire

>>> src/grb_core.sv
// register state, access decode, read mux and pin drive decode
`timescale 1ns / 1ps
`default_nettype none
module grb_core import grb_pkg::*; #(
  parameter int PinCount = PIN_COUNT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 go_i,
  input  wire req_t                 req_i,
  input  wire logic [PinCount-1:0]  levels_i,
  output      logic [WORD_BITS-1:0] read_data_o,
  output      logic [PinCount-1:0]  drive_levels_o,
  output      logic [PinCount-1:0]  drive_enables_o,
  output      logic [PinCount-1:0]  pull_ups_o,
  output      logic [PinCount-1:0]  pull_downs_o
);

  logic wr_go;
  logic [PinCount-1:0][FN_W-1:0]   fn_q, fn_d;
  logic [PinCount-1:0]             lat_q, lat_d;
  logic [PinCount-1:0][PULL_W-1:0] ps_q, ps_d;
  logic [PULL_W-1:0]               pc_q, pc_d;
  logic [WORD_BITS-1:0]            clk0_q, clk0_d, clk1_q, clk1_d;
  logic [SEL_PINS*FN_W-1:0]        sel_flat;
  logic [SEL_BITS-1:0]             sel_words [SEL_WORDS];
  logic [LEV_BITS-1:0]             lev_all;
  logic [WORD_BITS-1:0]            rd;

  assign wr_go = go_i && (req_i.op == OP_WRITE);

  // per-pin next state
  for (genvar p = 0; p < PinCount; p++) begin : g_pin
    localparam int Half = p / WORD_BITS;
    localparam int Bit  = p % WORD_BITS;
    localparam logic [IDX_W-1:0] SetIdx = IDX_SET0 + IDX_W'(Half);
    localparam logic [IDX_W-1:0] ClrIdx = IDX_CLR0 + IDX_W'(Half);
    localparam logic [IDX_W-1:0] ClkIdx = IDX_CLK0 + IDX_W'(Half);

    if (p < SEL_PINS) begin : g_sel
      localparam int Word = p / PINS_PER_SEL;
      localparam int Fld  = p % PINS_PER_SEL;
      localparam logic [IDX_W-1:0] SelIdx = IDX_FSEL_FIRST + IDX_W'(Word);
      assign fn_d[p] = (wr_go && req_i.idx == SelIdx) ? req_i.data[Fld*FN_W +: FN_W]
                                                       : fn_q[p];
    end else begin : g_nosel
      assign fn_d[p] = '0;
    end

    assign lat_d[p] = (wr_go && req_i.idx == SetIdx && req_i.data[Bit]) ? 1'b1 :
                      (wr_go && req_i.idx == ClrIdx && req_i.data[Bit]) ? 1'b0 :
                      lat_q[p];
    assign ps_d[p]  = (wr_go && req_i.idx == ClkIdx && req_i.data[Bit]) ? pc_q : ps_q[p];

    assign drive_levels_o[p]  = lat_d[p];
    assign drive_enables_o[p] = (fn_d[p] == FN_OUTPUT);
    assign pull_ups_o[p]      = (ps_d[p] == PULL_UP);
    assign pull_downs_o[p]    = (ps_d[p] == PULL_DOWN);
  end

  assign pc_d   = (wr_go && req_i.idx == IDX_PULL) ? req_i.data[PULL_W-1:0] : pc_q;
  assign clk0_d = (wr_go && req_i.idx == IDX_CLK0) ? req_i.data : clk0_q;
  assign clk1_d = (wr_go && req_i.idx == IDX_CLK1) ? req_i.data : clk1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fn_q   <= '0;
      lat_q  <= '0;
      ps_q   <= '0;
      pc_q   <= '0;
      clk0_q <= '0;
      clk1_q <= '0;
    end else begin
      fn_q   <= fn_d;
      lat_q  <= lat_d;
      ps_q   <= ps_d;
      pc_q   <= pc_d;
      clk0_q <= clk0_d;
      clk1_q <= clk1_d;
    end
  end

  // select words, missing pins read as zero
  for (genvar p = 0; p < SEL_PINS; p++) begin : g_flat
    if (p < PinCount) begin : g_have
      assign sel_flat[p*FN_W +: FN_W] = fn_q[p];
    end else begin : g_miss
      assign sel_flat[p*FN_W +: FN_W] = '0;
    end
  end

  for (genvar w = 0; w < SEL_WORDS; w++) begin : g_word
    assign sel_words[w] = sel_flat[w*SEL_BITS +: SEL_BITS];
  end

  assign lev_all = LEV_BITS'(levels_i);

  always_comb begin
    rd = '0;
    case (req_i.idx) inside
      [IDX_FSEL_FIRST:IDX_FSEL_LAST]: rd = WORD_BITS'(sel_words[req_i.idx[2:0]]);
      IDX_LEV0: rd = lev_all[WORD_BITS-1:0];
      IDX_LEV1: rd = lev_all[LEV_BITS-1:WORD_BITS];
      IDX_PULL: rd = WORD_BITS'(pc_q);
      IDX_CLK0: rd = clk0_q;
      IDX_CLK1: rd = clk1_q;
      default:  rd = '0;
    endcase
  end

  assign read_data_o = (req_i.op == OP_WRITE) ? '0 : rd;

endmodule
`default_nettype wire

>>> src/grb_out_stage.sv
// result register with hold under stall
`timescale 1ns / 1ps
`default_nettype none
module grb_out_stage import grb_pkg::*; #(
  parameter int PinCount = PIN_COUNT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  output      logic                 ready_o,
  input  wire logic [WORD_BITS-1:0] read_data_i,
  input  wire logic [PinCount-1:0]  drive_levels_i,
  input  wire logic [PinCount-1:0]  drive_enables_i,
  input  wire logic [PinCount-1:0]  pull_ups_i,
  input  wire logic [PinCount-1:0]  pull_downs_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_stall_i,
  output      logic [WORD_BITS-1:0] read_data_o,
  output      logic [PinCount-1:0]  drive_levels_o,
  output      logic [PinCount-1:0]  drive_enables_o,
  output      logic [PinCount-1:0]  pull_ups_o,
  output      logic [PinCount-1:0]  pull_downs_o
);

  logic valid_q, valid_d;
  logic [WORD_BITS-1:0] read_data_q;
  logic [PinCount-1:0]  drive_levels_q, drive_enables_q, pull_ups_q, pull_downs_q;

  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      read_data_q     <= read_data_i;
      drive_levels_q  <= drive_levels_i;
      drive_enables_q <= drive_enables_i;
      pull_ups_q      <= pull_ups_i;
      pull_downs_q    <= pull_downs_i;
    end
  end

  assign out_valid_o     = valid_q;
  assign read_data_o     = read_data_q;
  assign drive_levels_o  = drive_levels_q;
  assign drive_enables_o = drive_enables_q;
  assign pull_ups_o      = pull_ups_q;
  assign pull_downs_o    = pull_downs_q;

endmodule
`default_nettype wire

>>> src/gpio_register_block_unit.sv
// top level of the pin controller register block
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------------
//   in      | to block  | in_valid_i/in_stall_o | operation, register_index, write_data, pins
//   out     | from block| out_valid_o/out_stall_i| read_data, drive/enable/pull vectors
//
// each request passes the input register, then decode and state update into the
// result register; one request per cycle sustained while out_stall_i stays low
// state updates commit when a request moves into the result register
// reset clears all pin state, pull control and clock words
// the input side stalls only while the result register holds a stalled result
`timescale 1ns / 1ps
`default_nettype none
module gpio_register_block_unit import grb_pkg::*; #(
  parameter int PinCount = PIN_COUNT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_stall_o,
  input  wire logic                 operation_i,
  input  wire logic [IDX_W-1:0]     register_index_i,
  input  wire logic [WORD_BITS-1:0] write_data_i,
  input  wire logic [PinCount-1:0]  pin_levels_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_stall_i,
  output      logic [WORD_BITS-1:0] read_data_o,
  output      logic [PinCount-1:0]  drive_levels_o,
  output      logic [PinCount-1:0]  drive_enables_o,
  output      logic [PinCount-1:0]  pull_ups_o,
  output      logic [PinCount-1:0]  pull_downs_o
);

  req_t                 in_req, s1_req;
  logic [PinCount-1:0]  s1_levels;
  logic                 go, out_ready;
  logic [WORD_BITS-1:0] rd;
  logic [PinCount-1:0]  dl, de, pu, pd;

  assign in_req.op   = operation_i;
  assign in_req.idx  = register_index_i;
  assign in_req.data = write_data_i;

  grb_in_stage #(.PinCount(PinCount)) u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_i       (in_req),
    .levels_i    (pin_levels_i),
    .out_ready_i (out_ready),
    .go_o        (go),
    .req_o       (s1_req),
    .levels_o    (s1_levels)
  );

  grb_core #(.PinCount(PinCount)) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .go_i            (go),
    .req_i           (s1_req),
    .levels_i        (s1_levels),
    .read_data_o     (rd),
    .drive_levels_o  (dl),
    .drive_enables_o (de),
    .pull_ups_o      (pu),
    .pull_downs_o    (pd)
  );

  grb_out_stage #(.PinCount(PinCount)) u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (go),
    .ready_o         (out_ready),
    .read_data_i     (rd),
    .drive_levels_i  (dl),
    .drive_enables_i (de),
    .pull_ups_i      (pu),
    .pull_downs_i    (pd),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .read_data_o     (read_data_o),
    .drive_levels_o  (drive_levels_o),
    .drive_enables_o (drive_enables_o),
    .pull_ups_o      (pull_ups_o),
    .pull_downs_o    (pull_downs_o)
  );

endmodule
`default_nettype wire

>>> src/grb_checker.sv
// port-level checks for the pin controller register block, with bind
`timescale 1ns / 1ps
`default_nettype none
module grb_checker import grb_pkg::*; #(
  parameter int PinCount = PIN_COUNT
) (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_stall_o,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire logic [WORD_BITS-1:0] read_data_o,
  input wire logic [PinCount-1:0]  drive_levels_o,
  input wire logic [PinCount-1:0]  pull_ups_o,
  input wire logic [PinCount-1:0]  pull_downs_o
);

  // input stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  // a pin is never pulled both ways
  a_pull_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((pull_ups_o & pull_downs_o) == '0))
    else $error("pin pulled up and down at once");

  // a fresh result follows an accepted request that passed through the input register
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a matching request");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(read_data_o)
                                      && $stable(drive_levels_o)))
    else $error("stalled result changed");

endmodule

bind gpio_register_block_unit grb_checker #(.PinCount(PinCount)) u_grb_checker (.*);
`default_nettype wire

>>> test/gpio_register_block_unit_tb.sv
// self-checking testbench for the pin controller register block: directed and random requests
`timescale 1ns / 1ps
module gpio_register_block_unit_tb;
  import grb_pkg::*;

  localparam logic [IDX_W-1:0] IDX_SET1    = IDX_SET0 + 6'd1;
  localparam logic [IDX_W-1:0] IDX_CLR1    = IDX_CLR0 + 6'd1;
  localparam logic [IDX_W-1:0] IDX_GAP     = 6'd6;
  localparam logic [IDX_W-1:0] IDX_TOP     = 6'd63;
  localparam int               CYCLE_LIMIT = 200000;
  localparam int               DRAIN_LIMIT = 1000;

  typedef struct packed {
    logic [WORD_BITS-1:0] read_data;
    logic [PIN_COUNT-1:0] drive_levels;
    logic [PIN_COUNT-1:0] drive_enables;
    logic [PIN_COUNT-1:0] pull_ups;
    logic [PIN_COUNT-1:0] pull_downs;
  } access_result_t;

  logic                 clk_i            = 1'b0;
  logic                 rst_ni           = 1'b0;
  logic                 in_valid_i       = 1'b0;
  logic                 in_stall_o;
  logic                 operation_i      = OP_READ;
  logic [IDX_W-1:0]     register_index_i = IDX_FSEL_FIRST;
  logic [WORD_BITS-1:0] write_data_i     = '0;
  logic [PIN_COUNT-1:0] pin_levels_i     = '0;
  logic                 out_valid_o;
  logic                 out_stall_i      = 1'b0;
  logic [WORD_BITS-1:0] read_data_o;
  logic [PIN_COUNT-1:0] drive_levels_o;
  logic [PIN_COUNT-1:0] drive_enables_o;
  logic [PIN_COUNT-1:0] pull_ups_o;
  logic [PIN_COUNT-1:0] pull_downs_o;

  gpio_register_block_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .register_index_i (register_index_i),
    .write_data_i     (write_data_i),
    .pin_levels_i     (pin_levels_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .read_data_o      (read_data_o),
    .drive_levels_o   (drive_levels_o),
    .drive_enables_o  (drive_enables_o),
    .pull_ups_o       (pull_ups_o),
    .pull_downs_o     (pull_downs_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the pin state
  logic [FN_W-1:0]      pin_fn [PIN_COUNT];
  logic [PIN_COUNT-1:0] latch_bits;
  logic [PULL_W-1:0]    pull_ctrl;
  logic [WORD_BITS-1:0] clk_words [2];
  logic [PULL_W-1:0]    pull_st [PIN_COUNT];

  access_result_t expected_access_q [$];

  logic idle_on = 1'b0;
  int   mismatches = 0;
  int   n_requests = 0;
  int   n_writes = 0;
  int   n_results = 0;
  int   cycles = 0;
  int   stall_left = 0;

  function automatic void clear_shadow();
    for (int p = 0; p < PIN_COUNT; p++) begin
      pin_fn[p]  = '0;
      pull_st[p] = '0;
    end
    latch_bits   = '0;
    pull_ctrl    = '0;
    clk_words[0] = '0;
    clk_words[1] = '0;
  endfunction

  function automatic access_result_t predict_access(logic op, logic [IDX_W-1:0] idx,
                                                    logic [WORD_BITS-1:0] data,
                                                    logic [PIN_COUNT-1:0] lev);
    access_result_t       r;
    logic [LEV_BITS-1:0]  lev_wide;
    logic [WORD_BITS-1:0] rd;
    int                   p;
    int                   half;
    rd       = '0;
    lev_wide = {{(LEV_BITS-PIN_COUNT){1'b0}}, lev};
    if (idx <= IDX_FSEL_LAST) begin
      for (int i = 0; i < PINS_PER_SEL; i++) begin
        p = int'(idx) * PINS_PER_SEL + i;
        if (p < PIN_COUNT) begin
          if (op == OP_WRITE) pin_fn[p] = data[FN_W*i +: FN_W];
          else rd[FN_W*i +: FN_W] = pin_fn[p];
        end
      end
    end else if (idx == IDX_SET0 || idx == IDX_SET1 || idx == IDX_CLR0 || idx == IDX_CLR1) begin
      half = (idx == IDX_SET1 || idx == IDX_CLR1) ? 1 : 0;
      if (op == OP_WRITE) begin
        for (int b = 0; b < WORD_BITS; b++) begin
          p = half * WORD_BITS + b;
          if (p < PIN_COUNT && data[b]) latch_bits[p] = (idx == IDX_SET0 || idx == IDX_SET1);
        end
      end
    end else if (idx == IDX_LEV0 || idx == IDX_LEV1) begin
      half = (idx == IDX_LEV1) ? 1 : 0;
      if (op == OP_READ) rd = lev_wide[WORD_BITS*half +: WORD_BITS];
    end else if (idx == IDX_PULL) begin
      if (op == OP_WRITE) pull_ctrl = data[PULL_W-1:0];
      else rd = {{(WORD_BITS-PULL_W){1'b0}}, pull_ctrl};
    end else if (idx == IDX_CLK0 || idx == IDX_CLK1) begin
      half = (idx == IDX_CLK1) ? 1 : 0;
      if (op == OP_WRITE) begin
        clk_words[half] = data;
        for (int b = 0; b < WORD_BITS; b++) begin
          p = half * WORD_BITS + b;
          if (p < PIN_COUNT && data[b]) pull_st[p] = pull_ctrl;
        end
      end else begin
        rd = clk_words[half];
      end
    end
    r.read_data    = rd;
    r.drive_levels = latch_bits;
    for (int q = 0; q < PIN_COUNT; q++) begin
      r.drive_enables[q] = (pin_fn[q] == FN_OUTPUT);
      r.pull_ups[q]      = (pull_st[q] == PULL_UP);
      r.pull_downs[q]    = (pull_st[q] == PULL_DOWN);
    end
    return r;
  endfunction

  task automatic issue_request(input logic op, input logic [IDX_W-1:0] idx,
                               input logic [WORD_BITS-1:0] data,
                               input logic [PIN_COUNT-1:0] lev);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    operation_i      <= op;
    register_index_i <= idx;
    write_data_i     <= data;
    pin_levels_i     <= lev;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_access_q.push_back(predict_access(op, idx, data, lev));
    n_requests++;
    if (op == OP_WRITE) n_writes++;
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s at result %0d: expected %h, got %h", name, n_results, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_monitor
    access_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_access_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result %0d arrived with no request pending", n_results);
      end else begin
        want = expected_access_q.pop_front();
        check_field("read_data", 64'(want.read_data), 64'(read_data_o));
        check_field("drive_levels", 64'(want.drive_levels), 64'(drive_levels_o));
        check_field("drive_enables", 64'(want.drive_enables), 64'(drive_enables_o));
        check_field("pull_ups", 64'(want.pull_ups), 64'(pull_ups_o));
        check_field("pull_downs", 64'(want.pull_downs), 64'(pull_downs_o));
      end
      n_results++;
    end
  end

  // receiver backpressure in bursts
  always @(posedge clk_i) begin
    if (!idle_on) begin
      stall_left = 0;
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, expected_access_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [PIN_COUNT-1:0] rand_levels();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIN_COUNT'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] rand_index();
    logic [IDX_W-1:0] known [15] = '{IDX_FSEL_FIRST, 6'd1, 6'd2, 6'd3, 6'd4, IDX_FSEL_LAST,
                                     IDX_SET0, IDX_SET1, IDX_CLR0, IDX_CLR1, IDX_LEV0,
                                     IDX_LEV1, IDX_PULL, IDX_CLK0, IDX_CLK1};
    if ($urandom_range(0, 99) < 85) return known[$urandom_range(0, 14)];
    return IDX_W'($urandom_range(0, 63));
  endfunction

  function automatic logic [WORD_BITS-1:0] rand_data(logic [IDX_W-1:0] idx);
    logic [WORD_BITS-1:0] d;
    d = $urandom;
    case ($urandom_range(0, 9))
      0: d = '0;
      1: d = '1;
      2, 3: d = $urandom & $urandom;
      4, 5, 6: begin
        if (idx <= IDX_FSEL_LAST) begin
          for (int i = 0; i < PINS_PER_SEL; i++)
            if ($urandom_range(0, 1) == 1) d[FN_W*i +: FN_W] = FN_OUTPUT;
        end
      end
      default: ;
    endcase
    return d;
  endfunction

  task automatic random_requests(input int count);
    logic [IDX_W-1:0] idx;
    logic             op;
    for (int k = 0; k < count; k++) begin
      idx = rand_index();
      op  = ($urandom_range(0, 1) == 1) ? OP_WRITE : OP_READ;
      issue_request(op, idx, rand_data(idx), rand_levels());
    end
  endtask

  task automatic test_reset_readback();
    issue_request(OP_READ, IDX_FSEL_FIRST, '1, '1);
    issue_request(OP_READ, IDX_CLK1, '1, '0);
  endtask

  task automatic test_function_select();
    issue_request(OP_WRITE, IDX_FSEL_FIRST, 32'hFFFF_FFFF, '0);
    issue_request(OP_READ, IDX_FSEL_FIRST, '0, '0);
    // last select word only covers four pins
    issue_request(OP_WRITE, IDX_FSEL_LAST, 32'hFFFF_FFFF, '0);
    issue_request(OP_READ, IDX_FSEL_LAST, '0, '0);
    issue_request(OP_WRITE, IDX_FSEL_FIRST, 32'h0924_9249, '0);
    issue_request(OP_WRITE, IDX_FSEL_LAST, 32'h0924_9249, '0);
  endtask

  task automatic test_set_clear();
    issue_request(OP_WRITE, IDX_SET0, 32'hFFFF_FFFF, '0);
    issue_request(OP_WRITE, IDX_SET1, 32'hFFFF_FFFF, '0);
    issue_request(OP_READ, IDX_SET1, '0, '1);
    issue_request(OP_WRITE, IDX_CLR1, 32'hFFFF_FFFF, '0);
    issue_request(OP_WRITE, IDX_CLR0, 32'h0000_FFFF, '0);
    issue_request(OP_READ, IDX_CLR0, '0, '1);
  endtask

  task automatic test_levels();
    issue_request(OP_READ, IDX_LEV0, '0, '1);
    issue_request(OP_READ, IDX_LEV1, '0, '1);
    issue_request(OP_WRITE, IDX_LEV1, 32'hFFFF_FFFF, '1);
  endtask

  task automatic test_pull_latch();
    // reserved pull state shows as neither up nor down
    issue_request(OP_WRITE, IDX_PULL, 32'hFFFF_FFFF, '0);
    issue_request(OP_WRITE, IDX_CLK0, 32'hFFFF_FFFF, '0);
    issue_request(OP_READ, IDX_PULL, '0, '0);
    issue_request(OP_WRITE, IDX_PULL, 32'h0000_0002, '0);
    issue_request(OP_WRITE, IDX_CLK1, 32'hFFFF_FFFF, '0);
    issue_request(OP_WRITE, IDX_PULL, 32'h0000_0001, '0);
    issue_request(OP_WRITE, IDX_CLK0, 32'hAAAA_AAAA, '0);
    issue_request(OP_READ, IDX_CLK1, '0, '0);
  endtask

  task automatic test_unknown_offsets();
    issue_request(OP_WRITE, IDX_TOP, 32'hFFFF_FFFF, '1);
    issue_request(OP_READ, IDX_TOP, '0, '1);
    issue_request(OP_WRITE, IDX_GAP, 32'hFFFF_FFFF, '1);
  endtask

  task automatic test_random_with_idling();
    idle_on <= 1'b1;
    random_requests(1000);
  endtask

  task automatic test_back_to_back();
    idle_on <= 1'b0;
    random_requests(300);
  endtask

  initial begin : run
    int drain;
    drain = 0;
    clear_shadow();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_readback();
    test_function_select();
    test_set_clear();
    test_levels();
    test_pull_latch();
    test_unknown_offsets();
    test_random_with_idling();
    test_back_to_back();
    in_valid_i <= 1'b0;
    while (expected_access_q.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (4) @(posedge clk_i);
    if (expected_access_q.size() != 0) begin
      mismatches++;
      $display("%0d results never arrived", expected_access_q.size());
    end
    $display("covered %0d requests (%0d writes) over select, set, clear, level, pull, clock",
             n_requests, n_writes);
    $display("and unknown offsets; %0d results checked, %0d mismatches", n_results, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
